/* design/hca_pkg.sv */
// Shared types, constants and the arctangent table of the heading averager.
package hca_pkg;

    // Field and datapath widths
    localparam int HEADING_W = 15;
    localparam int Q15_W     = 16;
    localparam int CORDIC_W  = 40;
    localparam int ANGLE_W   = 24;
    localparam int STEPS     = 16;
    localparam int STEP_W    = 4;

    // Angles in 1/64 degree
    localparam logic [HEADING_W-1:0] FULL_TURN    = 15'd23040;
    localparam logic [HEADING_W-1:0] QUARTER_TURN = 15'd5760;

    // Gain-compensated unit vector at 2^30, and 180 degrees in 1/16384 degree
    localparam logic signed [CORDIC_W-1:0] GAIN_INIT      = 40'sd652032874;
    localparam logic signed [ANGLE_W-1:0]  HALF_TURN_FINE = 24'sd2949120;

    typedef enum logic {
        CM_ROTATE,
        CM_VECTOR
    } t_cordic_mode;

    typedef struct packed {
        logic         start;
        t_cordic_mode mode;
    } t_cordic_req;

    typedef struct packed {
        logic busy;
        logic done;
    } t_cordic_stat;

    // atan(2^-i) in 1/16384 degree, rounded
    function automatic logic signed [ANGLE_W-1:0] atan_fine(input logic [STEP_W-1:0] i);
        logic signed [ANGLE_W-1:0] a;
        unique case (i)
            4'd0:  a = 24'sd737280;
            4'd1:  a = 24'sd435242;
            4'd2:  a = 24'sd229970;
            4'd3:  a = 24'sd116736;
            4'd4:  a = 24'sd58595;
            4'd5:  a = 24'sd29326;
            4'd6:  a = 24'sd14667;
            4'd7:  a = 24'sd7334;
            4'd8:  a = 24'sd3667;
            4'd9:  a = 24'sd1833;
            4'd10: a = 24'sd917;
            4'd11: a = 24'sd458;
            4'd12: a = 24'sd229;
            4'd13: a = 24'sd115;
            4'd14: a = 24'sd57;
            default: a = 24'sd29;
        endcase
        return a;
    endfunction

endpackage

/* design/heading_circular_average.sv */
// Circular moving average of compass headings: ring memory of sin/cos pairs and CORDIC.
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+-------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_heading_in  (1/64 deg)
//  out     | output    | o_out_valid / i_out_ready  | o_heading_avg (1/64 deg)
//
// One word is in flight at a time; it goes through two 16-step passes of the
// single shared CORDIC unit (sine/cosine, then atan2) plus ring read, sum update
// and rounding steps, so a new word is taken only once the last one is through.
// Reset clears the ring valid bits, the sums and the write slot.
// A finished result sits in the output register, so the next word is taken
// while it waits; a stalled output holds the block only at its final step.
module heading_circular_average #(
    parameter int WINDOW = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [hca_pkg::HEADING_W-1:0]    i_heading_in,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [hca_pkg::HEADING_W-1:0]    o_heading_avg
);
    import hca_pkg::*;

    localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W  = Q15_W + $clog2(WINDOW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROT,
        S_SUM,
        S_VST,
        S_VEC,
        S_OUT
    } t_state;

    t_state                      r_state;
    logic [SLOT_W-1:0]           r_slot;
    logic [WINDOW-1:0]           r_vld;
    logic                        r_old_vld;
    logic [1:0]                  r_quad;
    logic signed [SUM_W-1:0]     r_sin_sum, r_cos_sum;
    logic signed [Q15_W-1:0]     r_new_sin, r_new_cos;
    logic                        r_zero;
    logic                        r_out_valid;
    logic [HEADING_W-1:0]        r_out;

    // Ring memory of {sin, cos}
    logic [2*Q15_W-1:0]          r_ring [WINDOW];
    logic [2*Q15_W-1:0]          r_rd;

    t_cordic_req                 req;
    t_cordic_stat                stat;
    logic signed [CORDIC_W-1:0]  c_x0, c_y0, c_x, c_y;
    logic signed [ANGLE_W-1:0]   c_z0, c_z;

    logic                        in_acc, mem_we, out_free;
    logic [HEADING_W-1:0]        h_mod, h_rem;
    logic [1:0]                  h_quad;
    logic signed [CORDIC_W-1:0]  map_c, map_s, cos_ext, sin_ext;
    logic signed [Q15_W-1:0]     old_sin, old_cos;
    logic signed [SUM_W-1:0]     n_sin_sum, n_cos_sum;
    logic signed [ANGLE_W-1:0]   z_rnd, z_fold;

    // Q1.15 rounding with saturation
    function automatic logic signed [Q15_W-1:0] to_q15(input logic signed [CORDIC_W-1:0] v);
        logic signed [CORDIC_W-1:0] r;
        r = (v + CORDIC_W'(16384)) >>> 15;
        if (r > CORDIC_W'(32767))
            return 16'sh7fff;
        else if (r < -CORDIC_W'(32768))
            return 16'sh8000;
        else
            return r[Q15_W-1:0];
    endfunction

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign out_free   = !r_out_valid || i_out_ready;
    assign mem_we     = (r_state == S_SUM);

    // Input reduction: modulo full turn, then quadrant and remainder
    always_comb begin
        h_mod = (i_heading_in >= FULL_TURN) ? i_heading_in - FULL_TURN : i_heading_in;
        if (h_mod >= 15'd17280) begin
            h_quad = 2'd3;
            h_rem  = h_mod - 15'd17280;
        end else if (h_mod >= 15'd11520) begin
            h_quad = 2'd2;
            h_rem  = h_mod - 15'd11520;
        end else if (h_mod >= QUARTER_TURN) begin
            h_quad = 2'd1;
            h_rem  = h_mod - QUARTER_TURN;
        end else begin
            h_quad = 2'd0;
            h_rem  = h_mod;
        end
    end

    // Quadrant map of the rotation result
    always_comb begin
        case (r_quad)
            2'd0: begin map_c = c_x;  map_s = c_y;  end
            2'd1: begin map_c = -c_y; map_s = c_x;  end
            2'd2: begin map_c = -c_x; map_s = -c_y; end
            default: begin map_c = c_y; map_s = -c_x; end
        endcase
    end

    // Oldest pair leaving the window; never-written slots read as zero
    assign old_sin   = r_old_vld ? signed'(r_rd[2*Q15_W-1:Q15_W]) : '0;
    assign old_cos   = r_old_vld ? signed'(r_rd[Q15_W-1:0])       : '0;
    assign n_sin_sum = r_sin_sum - SUM_W'(old_sin) + SUM_W'(r_new_sin);
    assign n_cos_sum = r_cos_sum - SUM_W'(old_cos) + SUM_W'(r_new_cos);

    // Sums scaled by 2^16 for atan2
    assign cos_ext = CORDIC_W'(r_cos_sum) <<< 16;
    assign sin_ext = CORDIC_W'(r_sin_sum) <<< 16;

    // CORDIC request and start values
    always_comb begin
        req.start = in_acc || (r_state == S_VST);
        req.mode  = (r_state == S_VST) ? CM_VECTOR : CM_ROTATE;
        if (r_state == S_VST) begin
            if (r_cos_sum[SUM_W-1]) begin
                c_x0 = -cos_ext;
                c_y0 = -sin_ext;
                c_z0 = HALF_TURN_FINE;
            end else begin
                c_x0 = cos_ext;
                c_y0 = sin_ext;
                c_z0 = '0;
            end
        end else begin
            c_x0 = GAIN_INIT;
            c_y0 = '0;
            c_z0 = signed'(ANGLE_W'({h_rem, 8'h00}));
        end
    end

    // Angle to 1/64 degree, folded into one turn
    always_comb begin
        z_rnd = (c_z + ANGLE_W'(128)) >>> 8;
        if (z_rnd[ANGLE_W-1])
            z_fold = z_rnd + ANGLE_W'(FULL_TURN);
        else if (z_rnd >= ANGLE_W'(FULL_TURN))
            z_fold = z_rnd - ANGLE_W'(FULL_TURN);
        else
            z_fold = z_rnd;
    end

    hca_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .i_x0    (c_x0),
        .i_y0    (c_y0),
        .i_z0    (c_z0),
        .o_stat  (stat),
        .o_x     (c_x),
        .o_y     (c_y),
        .o_z     (c_z)
    );

    // Ring memory: read the slot at acceptance, write the new pair in the sum update step
    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_ring[r_slot] <= {r_new_sin, r_new_cos};
        if (in_acc)
            r_rd <= r_ring[r_slot];
    end

    // Sequencer, sums and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_slot      <= '0;
            r_vld       <= '0;
            r_sin_sum   <= '0;
            r_cos_sum   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // Output word: loaded at the final step, cleared once taken
            if (r_state == S_OUT && out_free)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_quad    <= h_quad;
                        r_old_vld <= r_vld[r_slot];
                        r_state   <= S_ROT;
                    end
                end
                S_ROT: begin
                    if (stat.done) begin
                        r_new_sin <= to_q15(map_s);
                        r_new_cos <= to_q15(map_c);
                        r_state   <= S_SUM;
                    end
                end
                S_SUM: begin
                    r_sin_sum     <= n_sin_sum;
                    r_cos_sum     <= n_cos_sum;
                    r_zero        <= (n_sin_sum == '0) && (n_cos_sum == '0);
                    r_vld[r_slot] <= 1'b1;
                    r_slot        <= (r_slot == SLOT_W'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
                    r_state       <= S_VST;
                end
                S_VST: begin
                    r_state <= S_VEC;
                end
                S_VEC: begin
                    if (stat.done)
                        r_state <= S_OUT;
                end
                S_OUT: begin
                    // CORDIC angle holds until the next start
                    if (out_free) begin
                        r_out   <= r_zero ? '0 : z_fold[HEADING_W-1:0];
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_heading_avg = r_out;

    // Checks
    a_idle_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !stat.busy)
        else $error("CORDIC busy while sequencer idle");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (stat.busy && r_state == S_ROT))
        else $error("accepted word did not start the rotation pass");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.done |-> (r_state == S_ROT || r_state == S_VEC))
        else $error("CORDIC finished outside a waiting state");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW - 1))
        else $error("ring slot beyond window");

endmodule

/* design/hca_cordic.sv */
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
module hca_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  hca_pkg::t_cordic_req                  i_req,
    input  logic signed [hca_pkg::CORDIC_W-1:0]   i_x0,
    input  logic signed [hca_pkg::CORDIC_W-1:0]   i_y0,
    input  logic signed [hca_pkg::ANGLE_W-1:0]    i_z0,
    output hca_pkg::t_cordic_stat                 o_stat,
    output logic signed [hca_pkg::CORDIC_W-1:0]   o_x,
    output logic signed [hca_pkg::CORDIC_W-1:0]   o_y,
    output logic signed [hca_pkg::ANGLE_W-1:0]    o_z
);
    import hca_pkg::*;

    logic signed [CORDIC_W-1:0] r_x, r_y;
    logic signed [ANGLE_W-1:0]  r_z;
    logic [STEP_W-1:0]          r_step;
    logic                       r_busy, r_done;
    t_cordic_mode               r_mode;

    logic signed [CORDIC_W-1:0] dx, dy;
    logic signed [ANGLE_W-1:0]  da;
    logic                       turn_pos;

    // Shifted terms; >>> on signed values floors
    assign dx = r_y >>> r_step;
    assign dy = r_x >>> r_step;
    assign da = atan_fine(r_step);

    // Rotation follows the sign of z; vectoring drives y toward zero
    assign turn_pos = (r_mode == CM_ROTATE) ? !r_z[ANGLE_W-1]
                                            : (r_y[CORDIC_W-1] || !(|r_y));

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
            r_mode <= CM_ROTATE;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_mode <= i_req.mode;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x <= i_x0;
            r_y <= i_y0;
            r_z <= i_z0;
        end else if (r_busy) begin
            if (turn_pos) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - da;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + da;
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
